/* hdl/tprq_pkg.sv */
package tprq_pkg;

    localparam int DIST_W    = 16;
    localparam int TICK_W    = 32;
    localparam int AGE_W     = 16;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_OK   = 2'd2,
        ST_FAIL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_ENTER   = 2'd1,
        EV_ON_RAIL = 2'd2
    } rail_event_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_CONFIG  = 2'd1,
        CAUSE_TIMEOUT = 2'd2,
        CAUSE_STALE   = 2'd3
    } fail_cause_t;

    localparam logic [CFG_IDX_W-1:0] REG_ENTER_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_RAIL_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STALE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_CONFIRM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RAIL_CONFIRM  = 3'd5;

    localparam logic [DIST_W-1:0]  RST_ENTER_LEVEL   = 16'd120;
    localparam logic [DIST_W-1:0]  RST_ON_RAIL_LEVEL = 16'd160;
    localparam logic [TICK_W-1:0]  RST_TIMEOUT       = 32'd0;
    localparam logic [AGE_W-1:0]   RST_STALE         = 16'd500;
    localparam logic [COUNT_W-1:0] RST_ENTER_CONFIRM = 8'd2;
    localparam logic [COUNT_W-1:0] RST_RAIL_CONFIRM  = 8'd3;

endpackage

/* hdl/tprq_if.sv */
interface tprq_in_if;
    logic                             valid;
    logic                             ready;
    tprq_pkg::cmd_t                   cmd;
    logic [tprq_pkg::DIST_W-1:0]      range_mm;
    logic                             sample_bad;

    modport source (output valid, cmd, range_mm, sample_bad, input ready);
    modport sink   (input valid, cmd, range_mm, sample_bad, output ready);
endinterface

interface tprq_out_if;
    logic                             valid;
    logic                             ready;
    tprq_pkg::status_t                status;
    tprq_pkg::rail_event_t            rail_event;
    tprq_pkg::fail_cause_t            fail_cause;

    modport source (output valid, status, rail_event, fail_cause, input ready);
    modport sink   (input valid, status, rail_event, fail_cause, output ready);
endinterface

/* hdl/two_phase_range_qualifier_unit.sv */
// result: an input transfer's result is held in the output register from the next cycle
// throughput: one item per cycle; a new item is taken whenever the output register
// is empty or its result is transferred in the same cycle
// reset (rst_n low, asynchronous): run idle, phase, counters and sample flags cleared,
// configuration registers back to their defaults, output register empty
module two_phase_range_qualifier_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    tprq_in_if.sink                              sample_ch,
    tprq_out_if.source                           result_ch,
    input  logic                                 cfg_we,
    input  logic [tprq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tprq_pkg::CFG_W-1:0]           cfg_data
);

    // configuration registers
    logic [tprq_pkg::DIST_W-1:0]  enter_level_reg;
    logic [tprq_pkg::DIST_W-1:0]  on_rail_level_reg;
    logic [tprq_pkg::TICK_W-1:0]  timeout_reg;
    logic [tprq_pkg::AGE_W-1:0]   stale_reg;
    logic [tprq_pkg::COUNT_W-1:0] enter_confirm_reg;
    logic [tprq_pkg::COUNT_W-1:0] rail_confirm_reg;

    // run state
    logic                         active_reg, active_next;
    logic                         phase_reg, phase_next;
    logic [tprq_pkg::COUNT_W-1:0] low_count_reg, low_count_next;
    logic [tprq_pkg::COUNT_W-1:0] high_count_reg, high_count_next;
    logic                         have_sample_reg, have_sample_next;
    logic [tprq_pkg::DIST_W-1:0]  last_dist_reg, last_dist_next;
    logic [tprq_pkg::AGE_W-1:0]   age_reg, age_next;
    logic [tprq_pkg::TICK_W-1:0]  elapsed_reg, elapsed_next;

    // output register
    logic                         out_valid_reg;
    tprq_pkg::status_t            status_reg, status_next;
    tprq_pkg::rail_event_t        event_reg, event_next;
    tprq_pkg::fail_cause_t        cause_reg, cause_next;

    logic                         accept;
    logic                         cfg_bad;
    logic [tprq_pkg::AGE_W-1:0]   age_inc;
    logic [tprq_pkg::TICK_W-1:0]  elapsed_inc;
    logic [tprq_pkg::COUNT_W-1:0] low_inc;
    logic [tprq_pkg::COUNT_W-1:0] high_inc;
    logic                         fresh;

    // output register acts as the skid stage: take a new item while the
    // pending result is being transferred
    assign sample_ch.ready = !out_valid_reg || result_ch.ready;
    assign accept          = sample_ch.valid && sample_ch.ready;

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.status     = status_reg;
    assign result_ch.rail_event = event_reg;
    assign result_ch.fail_cause = cause_reg;

    // configuration check done at start only
    assign cfg_bad = (enter_level_reg == '0)
                  || (on_rail_level_reg <= enter_level_reg)
                  || (stale_reg == '0)
                  || (enter_confirm_reg == '0)
                  || (rail_confirm_reg == '0);

    // saturating increments
    assign age_inc     = (&age_reg)     ? age_reg     : age_reg + 1'b1;
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;

    // consecutive low / high evaluation counts, reset on a miss
    assign low_inc  = (last_dist_reg > enter_level_reg) ? '0
                    : ((&low_count_reg) ? low_count_reg : low_count_reg + 1'b1);
    assign high_inc = (last_dist_reg < on_rail_level_reg) ? '0
                    : ((&high_count_reg) ? high_count_reg : high_count_reg + 1'b1);

    // freshness uses the age after this tick
    assign fresh = have_sample_reg && (age_inc <= stale_reg);

    always_comb
    begin
        active_next      = active_reg;
        phase_next       = phase_reg;
        low_count_next   = low_count_reg;
        high_count_next  = high_count_reg;
        have_sample_next = have_sample_reg;
        last_dist_next   = last_dist_reg;
        age_next         = age_reg;
        elapsed_next     = elapsed_reg;
        status_next      = active_reg ? tprq_pkg::ST_RUN : tprq_pkg::ST_IDLE;
        event_next       = tprq_pkg::EV_NONE;
        cause_next       = tprq_pkg::CAUSE_NONE;

        case (sample_ch.cmd)
            tprq_pkg::CMD_START:
            begin
                if (cfg_bad)
                begin
                    active_next = 1'b0;
                    status_next = tprq_pkg::ST_FAIL;
                    cause_next  = tprq_pkg::CAUSE_CONFIG;
                end
                else
                begin
                    // a start while running restarts the run
                    active_next      = 1'b1;
                    phase_next       = 1'b0;
                    low_count_next   = '0;
                    high_count_next  = '0;
                    have_sample_next = 1'b0;
                    elapsed_next     = '0;
                    status_next      = tprq_pkg::ST_RUN;
                end
            end

            tprq_pkg::CMD_SAMPLE:
            begin
                // stored whether or not a run is active
                if (!sample_ch.sample_bad)
                begin
                    last_dist_next   = sample_ch.range_mm;
                    age_next         = '0;
                    have_sample_next = 1'b1;
                end
            end

            tprq_pkg::CMD_TICK:
            begin
                age_next = age_inc;
                if (active_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if ((timeout_reg != '0) && (elapsed_inc >= timeout_reg))
                    begin
                        active_next = 1'b0;
                        status_next = tprq_pkg::ST_FAIL;
                        cause_next  = tprq_pkg::CAUSE_TIMEOUT;
                    end
                    else if (!fresh)
                    begin
                        // initial wait for a first sample, then stale failure
                        if (elapsed_inc > {{(tprq_pkg::TICK_W-tprq_pkg::AGE_W){1'b0}}, stale_reg})
                        begin
                            active_next = 1'b0;
                            status_next = tprq_pkg::ST_FAIL;
                            cause_next  = tprq_pkg::CAUSE_STALE;
                        end
                    end
                    else if (!phase_reg)
                    begin
                        low_count_next = low_inc;
                        if (low_inc >= enter_confirm_reg)
                        begin
                            phase_next      = 1'b1;
                            high_count_next = '0;
                            event_next      = tprq_pkg::EV_ENTER;
                        end
                    end
                    else
                    begin
                        high_count_next = high_inc;
                        if (high_inc >= rail_confirm_reg)
                        begin
                            active_next = 1'b0;
                            status_next = tprq_pkg::ST_OK;
                            event_next  = tprq_pkg::EV_ON_RAIL;
                        end
                    end
                end
            end

            default:
            begin
                // unused command: no change
            end
        endcase
    end

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_level_reg   <= tprq_pkg::RST_ENTER_LEVEL;
            on_rail_level_reg <= tprq_pkg::RST_ON_RAIL_LEVEL;
            timeout_reg       <= tprq_pkg::RST_TIMEOUT;
            stale_reg         <= tprq_pkg::RST_STALE;
            enter_confirm_reg <= tprq_pkg::RST_ENTER_CONFIRM;
            rail_confirm_reg  <= tprq_pkg::RST_RAIL_CONFIRM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tprq_pkg::REG_ENTER_LEVEL:   enter_level_reg   <= cfg_data[tprq_pkg::DIST_W-1:0];
                tprq_pkg::REG_ON_RAIL_LEVEL: on_rail_level_reg <= cfg_data[tprq_pkg::DIST_W-1:0];
                tprq_pkg::REG_TIMEOUT:       timeout_reg       <= cfg_data[tprq_pkg::TICK_W-1:0];
                tprq_pkg::REG_STALE:         stale_reg         <= cfg_data[tprq_pkg::AGE_W-1:0];
                tprq_pkg::REG_ENTER_CONFIRM: enter_confirm_reg <= cfg_data[tprq_pkg::COUNT_W-1:0];
                tprq_pkg::REG_RAIL_CONFIRM:  rail_confirm_reg  <= cfg_data[tprq_pkg::COUNT_W-1:0];
                default:
                begin
                    // writes beyond the register list are ignored
                end
            endcase
        end
    end

    // run state, updated on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            phase_reg       <= 1'b0;
            low_count_reg   <= '0;
            high_count_reg  <= '0;
            have_sample_reg <= 1'b0;
            last_dist_reg   <= '0;
            age_reg         <= '0;
            elapsed_reg     <= '0;
        end
        else if (accept)
        begin
            active_reg      <= active_next;
            phase_reg       <= phase_next;
            low_count_reg   <= low_count_next;
            high_count_reg  <= high_count_next;
            have_sample_reg <= have_sample_next;
            last_dist_reg   <= last_dist_next;
            age_reg         <= age_next;
            elapsed_reg     <= elapsed_next;
        end
    end

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            event_reg  <= event_next;
            cause_reg  <= cause_next;
        end
    end

endmodule

/* hdl/tprq_checker.sv */
module tprq_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input tprq_pkg::cmd_t        in_cmd,
    input logic                  out_valid,
    input logic                  out_ready,
    input tprq_pkg::status_t     status,
    input tprq_pkg::rail_event_t rail_event,
    input tprq_pkg::fail_cause_t fail_cause
);

    // every input transfer leaves a result in the output register
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after input transfer");

    // a failure always carries a cause, and only a failure does
    a_cause_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == tprq_pkg::ST_FAIL) == (fail_cause != tprq_pkg::CAUSE_NONE)))
        else $error("fail cause does not match status");

    // on rail ends the run in success, entering keeps it running
    a_event_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rail_event != tprq_pkg::EV_NONE) |->
            ((rail_event == tprq_pkg::EV_ON_RAIL && status == tprq_pkg::ST_OK)
          || (rail_event == tprq_pkg::EV_ENTER && status == tprq_pkg::ST_RUN)))
        else $error("rail event with wrong status");

    // a start either runs or fails on configuration
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_cmd == tprq_pkg::CMD_START) |=>
            (status == tprq_pkg::ST_RUN
          || (status == tprq_pkg::ST_FAIL && fail_cause == tprq_pkg::CAUSE_CONFIG)))
        else $error("unexpected start result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(status) && $stable(rail_event) && $stable(fail_cause)))
        else $error("stalled result changed");

endmodule

bind two_phase_range_qualifier_unit tprq_checker u_tprq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_ch.valid),
    .in_ready   (sample_ch.ready),
    .in_cmd     (sample_ch.cmd),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .status     (result_ch.status),
    .rail_event (result_ch.rail_event),
    .fail_cause (result_ch.fail_cause)
);

/* test/tb_two_phase_range_qualifier_unit.sv */
module tb_two_phase_range_qualifier_unit;

    import tprq_pkg::*;

    // one result as the block reports it
    typedef struct packed {
        status_t     status;
        rail_event_t rail_ev;
        fail_cause_t cause;
    } rail_report_t;

    // mirrors the qualifier state and registers, holds the reports still owed
    class qualifier_scoreboard;
        logic [DIST_W-1:0]  enter_lvl   = RST_ENTER_LEVEL;
        logic [DIST_W-1:0]  rail_lvl    = RST_ON_RAIL_LEVEL;
        logic [TICK_W-1:0]  timeout_lim = RST_TIMEOUT;
        logic [AGE_W-1:0]   stale_lim   = RST_STALE;
        logic [COUNT_W-1:0] enter_conf  = RST_ENTER_CONFIRM;
        logic [COUNT_W-1:0] rail_conf   = RST_RAIL_CONFIRM;

        bit                 active          = 1'b0;
        bit                 in_second_phase = 1'b0;
        bit                 have_sample     = 1'b0;
        logic [COUNT_W-1:0] low_count       = '0;
        logic [COUNT_W-1:0] high_count      = '0;
        logic [DIST_W-1:0]  last_dist       = '0;
        logic [AGE_W-1:0]   sample_age      = '0;
        logic [TICK_W-1:0]  run_elapsed     = '0;

        rail_report_t expected_reports[$];
        int           mismatches   = 0;
        int           results_seen = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_ENTER_LEVEL:   enter_lvl   = data[DIST_W-1:0];
                REG_ON_RAIL_LEVEL: rail_lvl    = data[DIST_W-1:0];
                REG_TIMEOUT:       timeout_lim = data[TICK_W-1:0];
                REG_STALE:         stale_lim   = data[AGE_W-1:0];
                REG_ENTER_CONFIRM: enter_conf  = data[COUNT_W-1:0];
                REG_RAIL_CONFIRM:  rail_conf   = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // works out the report that an accepted command causes
        function void predict_item(cmd_t c, logic [DIST_W-1:0] meas, logic bad);
            rail_report_t r;
            r = '{status: ST_IDLE, rail_ev: EV_NONE, cause: CAUSE_NONE};
            case (c)
                CMD_START:
                begin
                    if (enter_lvl == 0 || rail_lvl <= enter_lvl || stale_lim == 0 ||
                        enter_conf == 0 || rail_conf == 0)
                    begin
                        active   = 1'b0;
                        r.status = ST_FAIL;
                        r.cause  = CAUSE_CONFIG;
                    end
                    else
                    begin
                        active          = 1'b1;
                        in_second_phase = 1'b0;
                        low_count       = '0;
                        high_count      = '0;
                        have_sample     = 1'b0;
                        run_elapsed     = '0;
                        r.status        = ST_RUN;
                    end
                end
                CMD_SAMPLE:
                begin
                    if (!bad)
                    begin
                        last_dist   = meas;
                        sample_age  = '0;
                        have_sample = 1'b1;
                    end
                    r.status = active ? ST_RUN : ST_IDLE;
                end
                CMD_TICK:
                begin
                    if (sample_age != '1)
                        sample_age++;
                    if (active)
                    begin
                        if (run_elapsed != '1)
                            run_elapsed++;
                        r.status = ST_RUN;
                        if (timeout_lim != 0 && run_elapsed >= timeout_lim)
                        begin
                            active   = 1'b0;
                            r.status = ST_FAIL;
                            r.cause  = CAUSE_TIMEOUT;
                        end
                        else if (!have_sample || sample_age > stale_lim)
                        begin
                            if (run_elapsed > stale_lim)
                            begin
                                active   = 1'b0;
                                r.status = ST_FAIL;
                                r.cause  = CAUSE_STALE;
                            end
                        end
                        else if (!in_second_phase)
                        begin
                            if (last_dist <= enter_lvl)
                                low_count = (low_count == '1) ? low_count : low_count + 1'b1;
                            else
                                low_count = '0;
                            if (low_count >= enter_conf)
                            begin
                                in_second_phase = 1'b1;
                                high_count      = '0;
                                r.rail_ev       = EV_ENTER;
                            end
                        end
                        else
                        begin
                            if (last_dist >= rail_lvl)
                                high_count = (high_count == '1) ? high_count : high_count + 1'b1;
                            else
                                high_count = '0;
                            if (high_count >= rail_conf)
                            begin
                                active    = 1'b0;
                                r.status  = ST_OK;
                                r.rail_ev = EV_ON_RAIL;
                            end
                        end
                    end
                end
                default: r.status = active ? ST_RUN : ST_IDLE;
            endcase
            expected_reports.push_back(r);
        endfunction

        function void log_fault(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        endfunction

        function void check_result(status_t st, rail_event_t ev, fail_cause_t fc);
            rail_report_t want;
            results_seen++;
            if (expected_reports.size() == 0)
            begin
                log_fault($sformatf("unexpected result status %0d event %0d cause %0d",
                                    st, ev, fc));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (st !== want.status || ev !== want.rail_ev || fc !== want.cause)
                    log_fault($sformatf("expected status %0d event %0d cause %0d, got %0d %0d %0d",
                                        want.status, want.rail_ev, want.cause, st, ev, fc));
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tprq_in_if  sample_if ();
    tprq_out_if result_if ();

    qualifier_scoreboard sb = new();

    // idling bounds for each side, and a one-off long hold on the result side
    int tx_max_gap = 12;
    int rx_max_gap = 12;
    int rx_hold    = 0;

    two_phase_range_qualifier_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_if),
        .result_ch (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(64'd5_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    // both channels observed at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
                sb.check_result(result_if.status, result_if.rail_event, result_if.fail_cause);
            if (sample_if.valid && sample_if.ready)
                sb.predict_item(sample_if.cmd, sample_if.range_mm, sample_if.sample_bad);
        end
    end

    // result side: a random hold before each transfer, or the long hold when asked
    initial
    begin : result_sink
        int gap;
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            else
            begin
                gap = $urandom_range(0, rx_max_gap);
            end
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid)
                @(posedge clk);
        end
    end

    // offers one command after a random gap and waits for its transfer
    task automatic send(input cmd_t c, input logic [DIST_W-1:0] d, input logic b);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid      <= 1'b1;
        sample_if.cmd        <= c;
        sample_if.range_mm   <= d;
        sample_if.sample_bad <= b;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
    endtask

    // stops offering and lets every owed report come out
    task automatic wait_drained();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // registers only change with the block idle
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // mostly sane thresholds, now and then the extremes or a broken setting
    task automatic randomise_config();
        logic [DIST_W-1:0]  enter_lvl;
        logic [DIST_W-1:0]  rail_lvl;
        logic [TICK_W-1:0]  timeout_lim;
        logic [AGE_W-1:0]   stale_lim;
        logic [COUNT_W-1:0] enter_conf;
        logic [COUNT_W-1:0] rail_conf;
        case ($urandom_range(0, 9))
            0:
            begin
                enter_lvl = 16'd1;
                rail_lvl  = 16'd2;
            end
            1:
            begin
                enter_lvl = 16'hFFFE;
                rail_lvl  = 16'hFFFF;
            end
            default:
            begin
                enter_lvl = 16'($urandom_range(1, 1000));
                rail_lvl  = enter_lvl + 16'($urandom_range(1, 300));
            end
        endcase
        timeout_lim = $urandom_range(0, 1) ? 32'($urandom_range(3, 60)) : '0;
        stale_lim   = 16'($urandom_range(1, 15));
        enter_conf  = 8'($urandom_range(1, 4));
        rail_conf   = 8'($urandom_range(1, 4));
        // occasional invalid setting so that starts get refused
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 4))
                0: enter_lvl  = '0;
                1: rail_lvl   = enter_lvl;
                2: stale_lim  = '0;
                3: enter_conf = '0;
                default: rail_conf = '0;
            endcase
        end
        write_cfg(REG_ENTER_LEVEL, CFG_W'(enter_lvl));
        write_cfg(REG_ON_RAIL_LEVEL, CFG_W'(rail_lvl));
        write_cfg(REG_TIMEOUT, CFG_W'(timeout_lim));
        write_cfg(REG_STALE, CFG_W'(stale_lim));
        write_cfg(REG_ENTER_CONFIRM, CFG_W'(enter_conf));
        write_cfg(REG_RAIL_CONFIRM, CFG_W'(rail_conf));
    endtask

    // distance biased towards the wanted side of the thresholds, some noise
    function automatic logic [DIST_W-1:0] pick_distance(bit want_low);
        int  r;
        bit  go_low;
        r      = $urandom_range(0, 9);
        go_low = (r >= 8) ? !want_low : want_low;
        if (r < 2)
            return DIST_W'($urandom);
        else if (r == 2)
            return sb.enter_lvl;
        else if (r == 3)
            return sb.rail_lvl;
        else if (go_low)
            return DIST_W'($urandom_range(0, sb.enter_lvl));
        else
            return DIST_W'($urandom_range(sb.rail_lvl, 16'hFFFF));
    endfunction

    initial
    begin : stimulus
        int phase_no;
        int i;
        int k;
        int run_len;
        int roll;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        sample_if.valid      = 1'b0;
        sample_if.cmd        = CMD_TICK;
        sample_if.range_mm   = '0;
        sample_if.sample_bad = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part, reset thresholds first ----
        // tick and samples while idle, then a started run whose samples stay above the enter level
        send(CMD_TICK, 16'h0000, 1'b0);
        send(CMD_SAMPLE, 16'hFFFF, 1'b1);
        send(CMD_SAMPLE, 16'h0000, 1'b0);
        send(CMD_START, 16'h0000, 1'b0);
        send(CMD_TICK, 16'hFFFF, 1'b1);
        send(CMD_TICK, 16'h0000, 1'b0);
        send(CMD_SAMPLE, 16'hFFFF, 1'b0);
        send(CMD_TICK, 16'h0000, 1'b0);
        send(CMD_TICK, 16'h0000, 1'b0);
        send(CMD_TICK, 16'h0000, 1'b0);
        send(CMD_TICK, 16'h0000, 1'b0);

        // each way the configuration check can refuse a start
        write_cfg(REG_ENTER_LEVEL, 32'd0);
        send(CMD_START, 16'h0000, 1'b0);
        write_cfg(REG_ENTER_LEVEL, 32'd120);
        write_cfg(REG_ON_RAIL_LEVEL, 32'd120);
        send(CMD_START, 16'h0000, 1'b0);
        write_cfg(REG_ON_RAIL_LEVEL, 32'd160);
        write_cfg(REG_STALE, 32'd0);
        send(CMD_START, 16'h0000, 1'b0);
        write_cfg(REG_STALE, 32'd500);
        write_cfg(REG_ENTER_CONFIRM, 32'd0);
        send(CMD_START, 16'h0000, 1'b0);
        write_cfg(REG_ENTER_CONFIRM, 32'd2);
        write_cfg(REG_RAIL_CONFIRM, 32'd0);
        send(CMD_START, 16'h0000, 1'b0);

        // timeout on the very first tick
        write_cfg(REG_RAIL_CONFIRM, 32'd1);
        write_cfg(REG_TIMEOUT, 32'd1);
        send(CMD_START, 16'h0000, 1'b0);
        send(CMD_TICK, 16'h0000, 1'b0);

        // no sample within the initial wait
        write_cfg(REG_TIMEOUT, 32'd0);
        write_cfg(REG_STALE, 32'd2);
        send(CMD_START, 16'h0000, 1'b0);
        send(CMD_TICK, 16'h0000, 1'b0);
        send(CMD_TICK, 16'h0000, 1'b0);
        send(CMD_TICK, 16'h0000, 1'b0);

        // restart while running forgets the held sample
        send(CMD_START, 16'h0000, 1'b0);
        send(CMD_SAMPLE, 16'd50, 1'b0);
        send(CMD_START, 16'h0000, 1'b0);
        send(CMD_TICK, 16'h0000, 1'b0);

        // ---- top of every register range the start check allows, no idling ----
        // ticks carry junk fields that must be ignored
        tx_max_gap = 0;
        rx_max_gap = 0;
        write_cfg(REG_ENTER_LEVEL, 32'hFFFE);
        write_cfg(REG_ON_RAIL_LEVEL, 32'hFFFF);
        write_cfg(REG_TIMEOUT, 32'hFFFF_FFFF);
        write_cfg(REG_STALE, 32'hFFFF);
        write_cfg(REG_ENTER_CONFIRM, 32'hFF);
        write_cfg(REG_RAIL_CONFIRM, 32'hFF);
        send(CMD_START, 16'h0000, 1'b0);
        send(CMD_SAMPLE, 16'hFFFF, 1'b0);
        repeat (20) send(CMD_TICK, 16'($urandom), 1'($urandom));
        send(CMD_SAMPLE, 16'h0000, 1'b0);
        repeat (20) send(CMD_TICK, 16'h0000, 1'b0);

        // ---- random runs under fresh settings per phase ----
        for (phase_no = 0; phase_no < 10; phase_no++)
        begin
            tx_max_gap = (phase_no % 4 == 1) ? 0 : 12;
            rx_max_gap = tx_max_gap;
            randomise_config();
            // long hold on the result side while commands keep coming
            if (phase_no == 6)
            begin
                tx_max_gap = 0;
                rx_hold    = 60;
            end
            k       = 0;
            run_len = 0;
            for (i = 0; i < 33; i++)
            begin
                if (k >= run_len)
                begin
                    send(CMD_START, 16'($urandom), 1'($urandom));
                    run_len = $urandom_range(6, 20);
                    k       = 0;
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        send(CMD_START, 16'($urandom), 1'($urandom));
                    else if (roll < 40)
                        send(CMD_SAMPLE, pick_distance(k < run_len / 2),
                             ($urandom_range(0, 9) == 0));
                    else
                        send(CMD_TICK, 16'($urandom), 1'($urandom));
                    k++;
                end
                // sender pauses mid-phase until every report is back
                if (phase_no == 8 && i == 20)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
